// ===== rtl/core/b2e_pkg.sv =====
package b2e_pkg;

    // one input item: six packed-bcd bytes
    typedef struct packed {
        logic [7:0] sec_bcd;
        logic [7:0] min_bcd;
        logic [7:0] hour_bcd;
        logic [7:0] day_bcd;
        logic [7:0] month_bcd;
        logic [7:0] year_bcd;
    } t_in;

    // one result item
    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        valid_res;
    } t_out;

    // classified item as it sits in the queue
    typedef struct packed {
        logic       ok;
        logic [6:0] yr_ofs;   // march-based year minus 1999, 0..101
        logic [3:0] mshift;   // month counted from march, 0..11
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_cls;

    // days from 1970-01-01 to 1999-03-01, less one for the 1-based day
    localparam logic [15:0] DAYS_BASE     = 16'd10650;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    // march-based year offset of 2100, the only non-leap century year in range
    localparam logic [6:0]  YR_OFS_2100   = 7'd101;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    // packed bcd byte decoded as hi * 10 + lo, nibbles above nine kept
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // days before the first of the month, year starting in march
    function automatic logic [8:0] doy_base(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/b2e_front.sv =====
module b2e_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  b2e_pkg::t_in  i_data,
    output logic          o_push,
    output b2e_pkg::t_cls o_cls,
    input  logic          i_full
);
    import b2e_pkg::*;

    logic       r_v;
    logic       n_v;
    t_cls       r_cls;
    t_cls       n_cls;
    logic       load;
    logic [7:0] se, mi, hr, dy, mo, yd;
    logic       late;   // march or later

    always_comb begin
        se   = bcd_decode(i_data.sec_bcd);
        mi   = bcd_decode(i_data.min_bcd);
        hr   = bcd_decode(i_data.hour_bcd);
        dy   = bcd_decode(i_data.day_bcd);
        mo   = bcd_decode(i_data.month_bcd);
        yd   = bcd_decode(i_data.year_bcd);
        late = (mo > 8'd2);

        n_cls.ok = (yd <= 8'd100) && (mo >= 8'd1) && (mo <= 8'd12) &&
                   (dy >= 8'd1) && (dy <= 8'd31) && (hr <= 8'd23) &&
                   (mi <= 8'd59) && (se <= 8'd59);
        // jan and feb belong to the previous march-based year
        n_cls.yr_ofs = late ? 7'(yd + 8'd1) : yd[6:0];
        n_cls.mshift = late ? 4'(mo - 8'd3) : 4'(mo + 8'd9);
        n_cls.day    = dy[4:0];
        n_cls.hour   = hr[4:0];
        n_cls.minute = mi[5:0];
        n_cls.second = se[5:0];
    end

    assign o_stall = r_v && i_full;
    assign o_push  = r_v && !i_full;
    assign o_cls   = r_cls;
    assign load    = i_valid && !o_stall;
    assign n_v     = load || (r_v && i_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ===== rtl/core/b2e_queue.sv =====
module b2e_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b2e_pkg::t_cls i_data,
    output logic          o_full,
    output logic          o_valid,
    output b2e_pkg::t_cls o_data,
    input  logic          i_pop
);
    import b2e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== rtl/core/b2e_back.sv =====
module b2e_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_pop,
    input  b2e_pkg::t_cls i_cls,
    output logic          o_valid,
    output b2e_pkg::t_out o_res,
    input  logic          i_stall
);
    import b2e_pkg::*;

    logic adv;

    // stage 1: year days, month days, time-of-day partials
    logic        r_v1;
    logic        r_ok1;
    logic [15:0] r_yday;
    logic [8:0]  r_mday;
    logic [16:0] r_hsec;
    logic [11:0] r_msec;
    logic [15:0] n_yday;
    logic [8:0]  n_mday;
    logic [16:0] n_hsec;
    logic [11:0] n_msec;
    logic [15:0] k16;

    // stage 2: day count and seconds of day
    logic        r_v2;
    logic        r_ok2;
    logic [15:0] r_days;
    logic [16:0] r_tod2;

    // stage 3: day count scaled to seconds
    logic        r_v3;
    logic        r_ok3;
    logic [31:0] r_prod;
    logic [16:0] r_tod3;

    // output register
    logic        r_out_v;
    t_out        r_res;

    assign adv   = !r_out_v || !i_stall;
    assign o_pop = adv && i_valid;

    always_comb begin
        k16    = {9'd0, i_cls.yr_ofs};
        n_yday = k16 * DAYS_PER_YEAR + ((k16 + 16'd3) >> 2)
               - {15'd0, (i_cls.yr_ofs == YR_OFS_2100)};
        n_mday = doy_base(i_cls.mshift) + {4'd0, i_cls.day};
        n_hsec = {12'd0, i_cls.hour} * SECS_PER_HOUR;
        n_msec = {6'd0, i_cls.minute} * SECS_PER_MIN + {6'd0, i_cls.second};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_out_v <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ok1  <= i_cls.ok;
            r_yday <= n_yday;
            r_mday <= n_mday;
            r_hsec <= n_hsec;
            r_msec <= n_msec;

            r_ok2  <= r_ok1;
            r_days <= DAYS_BASE + r_yday + {7'd0, r_mday};
            r_tod2 <= r_hsec + {5'd0, r_msec};

            r_ok3  <= r_ok2;
            r_prod <= {16'd0, r_days} * SECS_PER_DAY;
            r_tod3 <= r_tod2;

            r_res.valid_res     <= r_ok3;
            r_res.epoch_seconds <= r_ok3 ? r_prod + {15'd0, r_tod3} : 32'd0;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/bcd_datetime_to_epoch_unit.sv =====
// bcd date/time to unix epoch seconds
//
// input channel (i_valid / o_stall / i_data): one item is six packed-bcd
// bytes, second through two-digit year of 20xx. an item is taken at a clock
// edge with i_valid high and o_stall low.
// output channel (o_valid / i_stall / o_data): one result item per input
// item, in order: utc seconds since 1970-01-01 and a flag that is set when
// every decoded field passed its range check (zero seconds otherwise).
//
// from acceptance to o_valid an item passes one front register that decodes
// and range-checks, the queue, then four back stages (day partials, day sum,
// multiply by 86400, final add).
// throughput is one item per cycle while neither side stalls.
// when the receiver stalls a shown result, the back pipeline and output hold
// still while the front keeps filling the queue; o_stall rises only once the queue is
// full and the front register holds an item.
// synchronous active-low reset empties the front register, queue and back
// pipeline; no result is shown until new items arrive.
module bcd_datetime_to_epoch_unit #(
    parameter int QUEUE_DEPTH = 4   // entries between front and back, 2 or more
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  b2e_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output b2e_pkg::t_out o_data
);
    import b2e_pkg::*;

    // front to queue
    logic q_push;
    logic q_full;
    t_cls f_cls;

    // queue to back
    logic q_valid;
    logic q_pop;
    t_cls q_cls;

    // decode, range-check, fold the month into a march-based year
    b2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (q_push),
        .o_cls   (f_cls),
        .i_full  (q_full)
    );

    // decouples the front from output stalls
    b2e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cls),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cls),
        .i_pop   (q_pop)
    );

    // day count and seconds arithmetic, with the output register
    b2e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_cls   (q_cls),
        .o_valid (o_valid),
        .o_res   (o_data),
        .i_stall (i_stall)
    );

endmodule

// ===== rtl/core/b2e_checker.sv =====
module b2e_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_stall,
    input b2e_pkg::t_in  i_in_data,
    input logic          i_out_valid,
    input logic          i_out_stall,
    input b2e_pkg::t_out i_out_data
);
    import b2e_pkg::*;

    localparam logic [31:0] EPOCH_MAX = 32'd4133980799;

    // a rejected item never carries a time
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.valid_res |-> i_out_data.epoch_seconds == 32'd0)
        else $error("rejected item with nonzero seconds");

    // accepted dates stay inside 2000-01-01 .. 2100-12-31
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.valid_res |->
            i_out_data.epoch_seconds >= 32'd946684800 &&
            i_out_data.epoch_seconds <= EPOCH_MAX)
        else $error("seconds out of range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown after reset");

    // with the input stalled the queue is full, so a result is pending
    a_stall_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid)
        else $error("input stalled with empty output");

    logic unused_in;
    assign unused_in = i_in_valid ^ (^i_in_data);

endmodule

bind bcd_datetime_to_epoch_unit b2e_checker u_b2e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_in_data   (i_data),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_data  (o_data)
);
